// ----- sv/les_pkg.sv -----
// ----------------------------------------------------------------------------
// les_pkg: shared types and constants of the line ending scanner
// Byte codes, count widths, the command that the front hands to the back,
// and the saturating increment used on offsets and counts.
// ----------------------------------------------------------------------------
package les_pkg;

	localparam int CNT_W = 31;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [7:0] BYTE_TAB   = 8'd9;
	localparam logic [7:0] BYTE_LF    = 8'd10;
	localparam logic [7:0] BYTE_CR    = 8'd13;
	localparam logic [7:0] ASCII_LOW  = 8'd32;
	localparam logic [7:0] ASCII_HIGH = 8'd126;

	localparam logic [7:0] MARK_B0 = 8'hEF;
	localparam logic [7:0] MARK_B1 = 8'hBB;
	localparam logic [7:0] MARK_B2 = 8'hBF;

	// mark_phase value once the mark question is settled
	localparam logic [1:0] MARK_DONE = 2'd3;

	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [1:0] {
		CLS_TEXT,
		CLS_CR,
		CLS_LF,
		CLS_FIN
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [1:0] pre_adv;  // partial mark bytes that turn into text
		logic       bad;      // clears the plain-ASCII flag
		logic       mark;     // mark found (finish only)
	} cmd_t;

	typedef struct packed {
		logic             full;
		logic             empty;
	} fifo_stat_t;

	typedef struct packed {
		logic             result_kind;
		logic [CNT_W-1:0] line_start;
		logic [CNT_W-1:0] lone_cr_count;
		logic [CNT_W-1:0] lone_lf_count;
		logic [CNT_W-1:0] pair_count;
		logic             plain_ascii;
		logic             mark_seen;
		logic             chosen_crlf;
		logic             final_item;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [7:0] mark_byte(input logic [1:0] phase);
		logic [7:0] b;
		case (phase)
			2'd0:    b = MARK_B0;
			2'd1:    b = MARK_B1;
			default: b = MARK_B2;
		endcase
		return b;
	endfunction

endpackage

// ----- sv/les_if.sv -----
// ----------------------------------------------------------------------------
// les_if: channel interfaces of the line ending scanner
// Input bytes, result records and the configuration write channel.
// ----------------------------------------------------------------------------
interface les_in_if import les_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] text_byte;

	modport source (output valid, kind, text_byte, input ready);
	modport sink   (input valid, kind, text_byte, output ready);
endinterface

interface les_out_if import les_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             result_kind;
	logic [CNT_W-1:0] line_start;
	logic [CNT_W-1:0] lone_cr_count;
	logic [CNT_W-1:0] lone_lf_count;
	logic [CNT_W-1:0] pair_count;
	logic             plain_ascii;
	logic             mark_seen;
	logic             chosen_crlf;
	logic             final_item;

	modport source (output valid, result_kind, line_start, lone_cr_count, lone_lf_count,
		pair_count, plain_ascii, mark_seen, chosen_crlf, final_item, input ready);
	modport sink   (input valid, result_kind, line_start, lone_cr_count, lone_lf_count,
		pair_count, plain_ascii, mark_seen, chosen_crlf, final_item, output ready);
endinterface

interface les_cfg_if ();
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ----- sv/line_ending_scanner.sv -----
// ----------------------------------------------------------------------------
// line_ending_scanner: line start and line ending scanner
// Finds CR, LF and CRLF breaks in a byte stream and summarizes the text.
// ----------------------------------------------------------------------------
// Usage:
//   text   - input beats: kind 0 carries one byte, kind 1 finishes the text.
//   result - line start offsets (result_kind 0), then one summary beat
//            (result_kind 1, final_item 1) per finish.
//   cfg    - one-bit write of the ending chosen for text without breaks;
//            always ready, write it only while the block is idle.
// Throughput is one beat per cycle while the command queue is not full. The
// classifier pushes into a four-entry command queue at the accepting edge;
// the back end then loads the output register from the head of the queue, so a
// result passes through the queue and the output register. A line start
// after a CR appears only once the next beat shows that no LF follows. A
// finish behind a held CR gets its line start first, then the summary.
// When the receiver stalls the output register holds its beat, the queue
// fills, and text.ready drops once four commands are waiting.
// Reset clears all counts, the mark detector and the queue, and sets the
// default ending to LF. A finish returns the scan state to its reset values
// but keeps the configured default.
// ----------------------------------------------------------------------------
module line_ending_scanner import les_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	les_in_if.sink    text,
	les_out_if.source result,
	les_cfg_if.sink   cfg
);

	logic       default_crlf_q;
	logic       push;
	logic       pop;
	cmd_t       push_cmd;
	cmd_t       head;
	fifo_stat_t stat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_crlf_q <= 1'b0;
		end else if (cfg.valid) begin
			default_crlf_q <= cfg.data;
		end
	end

	les_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.stat   (stat),
		.push   (push),
		.cmd    (push_cmd)
	);

	les_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	les_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.stat         (stat),
		.default_crlf (default_crlf_q),
		.pop          (pop),
		.result       (result)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("command pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("command popped from an empty queue");

	a_summary_final: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.result_kind == result.final_item))
		else $error("final flag does not match the result kind");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> text.ready)
		else $error("input stalled with an empty queue");

endmodule

// ----- sv/les_front.sv -----
// ----------------------------------------------------------------------------
// les_front: input classifier
// Strips a leading byte order mark and turns every other beat into a command
// for the back end: text, CR, LF or finish, with the mark bookkeeping attached.
// ----------------------------------------------------------------------------
module les_front import les_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	les_in_if.sink       text,
	input  fifo_stat_t   stat,
	output logic         push,
	output cmd_t         cmd
);

	logic [1:0] phase_q, phase_d;
	logic       found_q, found_d;
	logic       accept;
	logic       non_ascii;

	assign text.ready = !stat.full;
	assign accept     = text.valid && text.ready;

	assign non_ascii = !(text.text_byte == BYTE_TAB ||
		(text.text_byte >= ASCII_LOW && text.text_byte <= ASCII_HIGH));

	always_comb begin
		phase_d     = phase_q;
		found_d     = found_q;
		push        = 1'b0;
		cmd.cls     = CLS_TEXT;
		cmd.pre_adv = 2'd0;
		cmd.bad     = 1'b0;
		cmd.mark    = found_q;
		if (accept) begin
			if (text.kind == KIND_FINISH) begin
				push     = 1'b1;
				cmd.cls  = CLS_FIN;
				cmd.bad  = (phase_q == 2'd1) || (phase_q == 2'd2);
				phase_d  = 2'd0;
				found_d  = 1'b0;
			end else if (phase_q != MARK_DONE && text.text_byte == mark_byte(phase_q)) begin
				// swallow a matching mark byte
				phase_d = phase_q + 2'd1;
				if (phase_q == 2'd2) begin
					found_d = 1'b1;
				end
			end else begin
				push = 1'b1;
				if (phase_q != MARK_DONE) begin
					cmd.pre_adv = phase_q;
					phase_d     = MARK_DONE;
				end
				if (text.text_byte == BYTE_CR) begin
					cmd.cls = CLS_CR;
				end else if (text.text_byte == BYTE_LF) begin
					cmd.cls = CLS_LF;
				end else begin
					cmd.cls = CLS_TEXT;
				end
				cmd.bad = (cmd.pre_adv != 2'd0) || (cmd.cls == CLS_TEXT && non_ascii);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			found_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			found_q <= found_d;
		end
	end

endmodule

// ----- sv/les_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// les_cmd_fifo: command queue
// A short register queue that decouples the classifier from the back end.
// ----------------------------------------------------------------------------
module les_cmd_fifo import les_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cmd_t       push_cmd,
	input  logic       pop,
	output cmd_t       head,
	output fifo_stat_t stat
);

	cmd_t               entry_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;

	assign stat.full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- sv/les_back.sv -----
// ----------------------------------------------------------------------------
// les_back: break pairing and result generation
// Holds back a CR for one command, keeps the offset and break counts, and
// loads line starts and the end summary into the output register.
// ----------------------------------------------------------------------------
module les_back import les_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         head,
	input  fifo_stat_t   stat,
	input  logic         default_crlf,
	output logic         pop,
	les_out_if.source    result
);

	logic [CNT_W-1:0] pos_q, pos_d;
	logic [CNT_W-1:0] cr_q, cr_d;
	logic [CNT_W-1:0] lf_q, lf_d;
	logic [CNT_W-1:0] pair_q, pair_d;
	logic             held_q, held_d;
	logic             ascii_q, ascii_d;
	logic             out_valid_q;
	result_t          out_q;

	logic [CNT_W-1:0] pos_eff;
	logic [CNT_W:0]   crs;
	logic             no_breaks;
	logic             chosen;
	logic             emit;
	logic             done;
	logic             go;
	logic             slot_free;
	result_t          res;

	// the offset is still zero while the mark is undecided, so partial mark
	// bytes simply set it
	assign pos_eff = (head.pre_adv != 2'd0) ? CNT_W'(head.pre_adv) : pos_q;

	assign crs       = {1'b0, cr_q} + {1'b0, pair_q};
	assign no_breaks = (cr_q == '0) && (lf_q == '0) && (pair_q == '0);
	// CR + CRLF > total / 2 reduces to CR + CRLF > LF
	assign chosen    = no_breaks ? default_crlf : (crs > {1'b0, lf_q});

	assign slot_free = !out_valid_q || result.ready;

	always_comb begin
		emit    = 1'b0;
		done    = 1'b1;
		res     = '0;
		pos_d   = sat_inc(pos_eff);
		cr_d    = cr_q;
		lf_d    = lf_q;
		pair_d  = pair_q;
		held_d  = held_q;
		ascii_d = ascii_q && !head.bad;
		case (head.cls)
			CLS_CR: begin
				emit           = held_q;
				res.line_start = pos_eff;
				if (held_q) begin
					cr_d = sat_inc(cr_q);
				end
				held_d = 1'b1;
			end
			CLS_LF: begin
				emit           = 1'b1;
				res.line_start = sat_inc(pos_eff);
				if (held_q) begin
					pair_d = sat_inc(pair_q);
				end else begin
					lf_d = sat_inc(lf_q);
				end
				held_d = 1'b0;
			end
			CLS_TEXT: begin
				emit           = held_q;
				res.line_start = pos_eff;
				if (held_q) begin
					cr_d = sat_inc(cr_q);
				end
				held_d = 1'b0;
			end
			default: begin
				emit  = 1'b1;
				pos_d = pos_q;
				if (held_q) begin
					// flush the held CR first, keep the finish at the head
					done           = 1'b0;
					res.line_start = pos_q;
					cr_d           = sat_inc(cr_q);
					held_d         = 1'b0;
					ascii_d        = ascii_q;
				end else begin
					res.result_kind   = 1'b1;
					res.lone_cr_count = cr_q;
					res.lone_lf_count = lf_q;
					res.pair_count    = pair_q;
					res.plain_ascii   = ascii_q && !head.bad;
					res.mark_seen     = head.mark;
					res.chosen_crlf   = chosen;
					res.final_item    = 1'b1;
					pos_d   = '0;
					cr_d    = '0;
					lf_d    = '0;
					pair_d  = '0;
					held_d  = 1'b0;
					ascii_d = 1'b1;
				end
			end
		endcase
	end

	assign go  = !stat.empty && (slot_free || !emit);
	assign pop = go && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			cr_q        <= '0;
			lf_q        <= '0;
			pair_q      <= '0;
			held_q      <= 1'b0;
			ascii_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				pos_q   <= pos_d;
				cr_q    <= cr_d;
				lf_q    <= lf_d;
				pair_q  <= pair_d;
				held_q  <= held_d;
				ascii_q <= ascii_d;
			end
			if (go && emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			out_q <= res;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.result_kind   = out_q.result_kind;
	assign result.line_start    = out_q.line_start;
	assign result.lone_cr_count = out_q.lone_cr_count;
	assign result.lone_lf_count = out_q.lone_lf_count;
	assign result.pair_count    = out_q.pair_count;
	assign result.plain_ascii   = out_q.plain_ascii;
	assign result.mark_seen     = out_q.mark_seen;
	assign result.chosen_crlf   = out_q.chosen_crlf;
	assign result.final_item    = out_q.final_item;

endmodule

// ----- verif/line_report_checker.sv -----
// ----------------------------------------------------------------------------
// line_report_checker: result checker of the line ending scanner
// Watches the text, result and configuration channels. Keeps its own copy of
// the scan state, works out the line starts and summaries that each accepted
// text beat should produce, and compares every result beat against them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_report_checker import les_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	les_in_if    text,
	les_out_if   result,
	les_cfg_if   cfg,
	output int   mismatches,
	output int   waiting
);

	result_t          line_reports[$];
	logic             dflt_crlf;
	logic [CNT_W-1:0] offset;
	logic [CNT_W-1:0] n_cr;
	logic [CNT_W-1:0] n_lf;
	logic [CNT_W-1:0] n_crlf;
	logic             cr_held;
	logic             plain;
	logic             has_mark;
	logic [1:0]       mark_step;
	int               results_seen;

	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic void clear_scan();
		offset    = '0;
		cr_held   = 1'b0;
		n_cr      = '0;
		n_lf      = '0;
		n_crlf    = '0;
		plain     = 1'b1;
		mark_step = 2'd0;
		has_mark  = 1'b0;
	endfunction

	function automatic void queue_report(input result_t rec);
		line_reports = {line_reports, rec};
	endfunction

	function automatic void push_line(input logic [CNT_W-1:0] at);
		result_t rec;
		rec = '0;
		rec.line_start = at;
		queue_report(rec);
	endfunction

	task automatic scan_beat(input logic kind, input logic [7:0] b);
		logic [7:0]       mark_want;
		logic             swallowed;
		logic [CNT_W+1:0] total;
		logic [CNT_W+1:0] crs;
		result_t          summary;
		swallowed = 1'b0;
		if (kind == KIND_BYTE) begin
			if (mark_step != MARK_DONE) begin
				case (mark_step)
					2'd0:    mark_want = MARK_B0;
					2'd1:    mark_want = MARK_B1;
					default: mark_want = MARK_B2;
				endcase
				if (b == mark_want) begin
					mark_step = mark_step + 2'd1;
					if (mark_step == MARK_DONE)
						has_mark = 1'b1;
					swallowed = 1'b1;
				end else begin
					// matched mark bytes turn into ordinary text
					repeat (mark_step) begin
						offset = count_up(offset);
						plain  = 1'b0;
					end
					mark_step = MARK_DONE;
				end
			end
			if (!swallowed) begin
				if (b == BYTE_CR) begin
					if (cr_held) begin
						n_cr = count_up(n_cr);
						push_line(offset);
					end
					cr_held = 1'b1;
				end else if (b == BYTE_LF) begin
					if (cr_held)
						n_crlf = count_up(n_crlf);
					else
						n_lf = count_up(n_lf);
					cr_held = 1'b0;
					push_line(count_up(offset));
				end else begin
					if (cr_held) begin
						n_cr = count_up(n_cr);
						push_line(offset);
						cr_held = 1'b0;
					end
					if (b != BYTE_TAB && (b < ASCII_LOW || b > ASCII_HIGH))
						plain = 1'b0;
				end
				offset = count_up(offset);
			end
		end else begin
			if (mark_step != 2'd0 && mark_step != MARK_DONE)
				plain = 1'b0;
			// flush a held CR ahead of the summary
			if (cr_held) begin
				n_cr = count_up(n_cr);
				push_line(offset);
				cr_held = 1'b0;
			end
			total = n_cr + n_lf + n_crlf;
			crs   = n_cr + n_crlf;
			summary = '0;
			summary.result_kind   = 1'b1;
			summary.lone_cr_count = n_cr;
			summary.lone_lf_count = n_lf;
			summary.pair_count    = n_crlf;
			summary.plain_ascii   = plain;
			summary.mark_seen     = has_mark;
			summary.chosen_crlf   = (total == 0) ? dflt_crlf : (crs > (total >> 1));
			summary.final_item    = 1'b1;
			queue_report(summary);
			clear_scan();
		end
	endtask

	task automatic report(input string msg);
		mismatches++;
		$display("%t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [CNT_W-1:0] got,
			input logic [CNT_W-1:0] want);
		if (got !== want)
			report($sformatf("result beat %0d: %s is %0d, expected %0d",
				results_seen, name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_crlf = 1'b0;
			clear_scan();
			line_reports.delete();
			results_seen = 0;
			waiting <= 0;
		end else begin
			if (cfg.valid && cfg.ready)
				dflt_crlf = cfg.data;
			if (text.valid && text.ready)
				scan_beat(text.kind, text.text_byte);
			if (result.valid && result.ready) begin : compare_beat
				result_t want;
				if (line_reports.size() == 0) begin
					report($sformatf("result beat %0d arrived with nothing expected",
						results_seen));
				end else begin
					want = line_reports.pop_front();
					check_field("result_kind", result.result_kind, want.result_kind);
					check_field("line_start", result.line_start, want.line_start);
					check_field("lone_cr_count", result.lone_cr_count, want.lone_cr_count);
					check_field("lone_lf_count", result.lone_lf_count, want.lone_lf_count);
					check_field("pair_count", result.pair_count, want.pair_count);
					check_field("plain_ascii", result.plain_ascii, want.plain_ascii);
					check_field("mark_seen", result.mark_seen, want.mark_seen);
					check_field("chosen_crlf", result.chosen_crlf, want.chosen_crlf);
					check_field("final_item", result.final_item, want.final_item);
				end
				results_seen++;
			end
			waiting <= line_reports.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: top of the line ending scanner testbench
// Drives directed texts (byte order marks whole, partial and broken, every
// break kind, a CR held into a finish, empty text, non-ASCII bytes), then
// random texts under both default endings with random idling on both sides
// and a long result stall. The checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import les_pkg::*; ();

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_BEATS = 100;

	logic clk;
	logic arst_n;
	logic steady;
	int   beats_sent;
	int   mismatches;
	int   waiting;
	int   cycles;

	les_in_if  text_ch ();
	les_out_if result_ch ();
	les_cfg_if cfg_ch ();

	line_ending_scanner DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	line_report_checker watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text_ch),
		.result     (result_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.waiting    (waiting)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// result side: random stalls, a calm window, and a long hold every so often
	initial begin
		int tick;
		int hold;
		tick = 0;
		hold = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (tick % 700 == 300)
				hold = 60;
			if (hold > 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else if (tick >= 1000 && tick < 1300) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= 36);
			end
		end
	end

	task automatic send_beat(input logic k, input logic [7:0] b);
		while (!steady && $urandom_range(99) < 36) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid     <= 1'b1;
		text_ch.kind      <= k;
		text_ch.text_byte <= b;
		do @(posedge clk); while (!text_ch.ready);
		beats_sent++;
	endtask

	task automatic write_default(input logic v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// drop valid, wait for every expected result, then let the queue settle
	task automatic await_drain();
		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_random_text();
		int mode;
		int len;
		int r;
		logic [7:0] b;
		mode = $urandom_range(99);
		len  = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
		if (mode < 10) begin
			// noise: raw bytes with stray finishes
			repeat (len)
				send_beat(($urandom_range(7) == 0) ? KIND_FINISH : KIND_BYTE,
					8'($urandom_range(255)));
		end else begin
			if (mode < 40) begin
				send_beat(KIND_BYTE, MARK_B0);
				send_beat(KIND_BYTE, MARK_B1);
				send_beat(KIND_BYTE, MARK_B2);
			end else if (mode < 50) begin
				send_beat(KIND_BYTE, MARK_B0);
				if ($urandom_range(1))
					send_beat(KIND_BYTE, MARK_B1);
			end
			repeat (len) begin
				r = $urandom_range(99);
				if (r < 15)
					b = BYTE_CR;
				else if (r < 30)
					b = BYTE_LF;
				else if (r < 36)
					b = BYTE_TAB;
				else if (r < 46)
					b = 8'($urandom_range(255));
				else
					b = 8'($urandom_range(ASCII_HIGH, ASCII_LOW));
				send_beat(KIND_BYTE, b);
			end
			send_beat(KIND_FINISH, 8'($urandom_range(255)));
		end
	endtask

	initial begin
		int target;
		arst_n = 1'b0;
		steady = 1'b0;
		beats_sent = 0;
		text_ch.valid     <= 1'b0;
		text_ch.kind      <= KIND_BYTE;
		text_ch.text_byte <= 8'h00;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.data       <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_default(1'b0);
		// empty text
		send_beat(KIND_FINISH, 8'h5A);
		// full mark, CRLF, tab, CR CR, lone LF, CR held into the finish
		send_beat(KIND_BYTE, MARK_B0);
		send_beat(KIND_BYTE, MARK_B1);
		send_beat(KIND_BYTE, MARK_B2);
		send_beat(KIND_BYTE, 8'h41);
		send_beat(KIND_BYTE, BYTE_CR);
		send_beat(KIND_BYTE, BYTE_LF);
		send_beat(KIND_BYTE, BYTE_TAB);
		send_beat(KIND_BYTE, BYTE_CR);
		send_beat(KIND_BYTE, BYTE_CR);
		send_beat(KIND_BYTE, ASCII_HIGH);
		send_beat(KIND_BYTE, BYTE_LF);
		send_beat(KIND_BYTE, BYTE_CR);
		send_beat(KIND_FINISH, 8'hFF);
		// mark broken after two bytes
		send_beat(KIND_BYTE, MARK_B0);
		send_beat(KIND_BYTE, MARK_B1);
		send_beat(KIND_BYTE, ASCII_LOW);
		send_beat(KIND_FINISH, 8'h00);
		// finish inside a partial mark
		send_beat(KIND_BYTE, MARK_B0);
		send_beat(KIND_FINISH, 8'h00);
		// bytes just outside the printable range
		send_beat(KIND_BYTE, 8'h1F);
		send_beat(KIND_BYTE, 8'h7F);
		send_beat(KIND_BYTE, 8'h80);
		send_beat(KIND_BYTE, 8'hFF);
		send_beat(KIND_BYTE, BYTE_LF);
		send_beat(KIND_FINISH, 8'hA5);
		await_drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_default(ph % 2 == 0);
			steady = (ph == 2);
			target = beats_sent + PHASE_BEATS;
			while (beats_sent < target)
				send_random_text();
			await_drain();
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
